// ===== hw/rtl/crcdf_pkg.sv =====
// Shared types, codes and the CRC-16/MODBUS byte step for the frame deframer.
`default_nettype none

package crcdf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;
    localparam logic [BYTE_W-1:0] END_MARKER_RST  = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_END_MARKER  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_PASS      = 3'd0,
        KIND_PAYLOAD   = 3'd1,
        KIND_GOOD      = 3'd2,
        KIND_CRC_ERR   = 3'd3,
        KIND_TRAIL_ERR = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_LEN    = 3'd2,
        PH_CMD    = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC_HI = 3'd5,
        PH_CRC_LO = 3'd6,
        PH_TRAIL  = 3'd7
    } t_phase;

    typedef struct packed {
        logic                 wr_en;
        logic [CFG_IDX_W-1:0] index;
        logic [BYTE_W-1:0]    data;
    } t_cfg_wr;

    // One classified byte: an optional frame result followed by an optional passthrough.
    typedef struct packed {
        logic              prim_valid;
        t_kind             prim_kind;
        logic              pass_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
    } t_rec;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc16_frame_deframer.sv =====
// Top level of the sync/length framed byte deframer with CRC-16/MODBUS check.
//
//  channel   handshake              payload
//  -------   ---------------------  -----------------------------------------------
//  input     i_push / o_full        i_rx_byte
//  result    o_empty / i_pop        o_kind, o_byte_value, o_command, o_payload_length,
//                                   o_last
//  config    i_cfg_wr_en            i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while o_full is low; the parser and byte-wide CRC step finish it in that cycle.
// A byte causing two results occupies the result port for two pop transactions.
// The four-entry record queue sets when o_full rises under a stalled consumer.
// Synchronous active-low reset; no clearing pass, the block is ready the cycle after.
`default_nettype none

module crc16_frame_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_byte_value,
    output logic [7:0]      o_command,
    output logic [7:0]      o_payload_length,
    output logic            o_last,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    import crcdf_pkg::*;

    t_cfg_wr cfg;
    t_rec    rec, head;
    logic    rec_valid, q_rd, q_full, q_empty;

    assign cfg.wr_en = i_cfg_wr_en;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;
    assign o_full    = q_full;
    assign o_empty   = q_empty;

    crcdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (i_push && !q_full),
        .i_rx_byte   (i_rx_byte),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    crcdf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (rec_valid),
        .i_wr_rec (rec),
        .i_rd     (q_rd),
        .o_head   (head),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    crcdf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_q_empty        (q_empty),
        .i_pop            (i_pop),
        .o_q_rd           (q_rd),
        .o_kind           (o_kind),
        .o_byte_value     (o_byte_value),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/crcdf_front.sv =====
// Front end: configuration registers, frame parser and running CRC; classifies each byte.
`default_nettype none

module crcdf_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire crcdf_pkg::t_cfg_wr i_cfg,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_rec_valid,
    output crcdf_pkg::t_rec        o_rec
);
    import crcdf_pkg::*;

    logic [BYTE_W-1:0] r_sync_first, r_sync_second, r_end_marker;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_data_count, n_data_count;
    logic [BYTE_W-1:0] r_frame_length, n_frame_length;
    logic [BYTE_W-1:0] r_frame_command, n_frame_command;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_crc_hi, n_crc_hi;

    logic [CRC_W-1:0]  crc_cur, crc_start;
    logic [BYTE_W-1:0] count_inc;
    logic              is_sf, is_ss, is_em, crc_ok, resync;
    t_rec              rec;

    assign crc_cur   = crc_byte(r_crc, i_rx_byte);
    assign crc_start = crc_byte(CRC_INIT, i_rx_byte);
    assign count_inc = r_data_count + 8'd1;
    assign is_sf     = (i_rx_byte == r_sync_first);
    assign is_ss     = (i_rx_byte == r_sync_second);
    assign is_em     = (i_rx_byte == r_end_marker);
    assign crc_ok    = ({r_crc_hi, i_rx_byte} == r_crc);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT:   if (is_sf) n_phase = PH_SYNC2;
            PH_SYNC2:  n_phase = is_ss ? PH_LEN : (is_sf ? PH_SYNC2 : PH_HUNT);
            PH_LEN:    n_phase = PH_CMD;
            PH_CMD:    n_phase = (r_frame_length == '0) ? PH_CRC_HI : PH_DATA;
            PH_DATA:   if (count_inc == r_frame_length) n_phase = PH_CRC_HI;
            PH_CRC_HI: n_phase = PH_CRC_LO;
            PH_CRC_LO: n_phase = crc_ok ? PH_TRAIL : (is_sf ? PH_SYNC2 : PH_HUNT);
            PH_TRAIL:  n_phase = is_sf && !is_em ? PH_SYNC2 : PH_HUNT;
            default:   n_phase = PH_HUNT;
        endcase
    end

    // datapath and classification
    always_comb begin
        n_data_count    = r_data_count;
        n_frame_length  = r_frame_length;
        n_frame_command = r_frame_command;
        n_crc           = r_crc;
        n_crc_hi        = r_crc_hi;
        resync          = 1'b0;
        rec.prim_valid  = 1'b0;
        rec.prim_kind   = KIND_PAYLOAD;
        unique case (r_phase)
            PH_HUNT:   resync = is_sf;
            PH_SYNC2: begin
                if (is_ss) n_crc = crc_cur;
                else       resync = is_sf;
            end
            PH_LEN: begin
                n_crc          = crc_cur;
                n_frame_length = i_rx_byte;
            end
            PH_CMD: begin
                n_crc           = crc_cur;
                n_frame_command = i_rx_byte;
                n_data_count    = '0;
            end
            PH_DATA: begin
                n_crc          = crc_cur;
                n_data_count   = count_inc;
                rec.prim_valid = 1'b1;
            end
            PH_CRC_HI: n_crc_hi = i_rx_byte;
            PH_CRC_LO: begin
                if (!crc_ok) begin
                    rec.prim_valid = 1'b1;
                    rec.prim_kind  = KIND_CRC_ERR;
                    resync         = is_sf;
                end
            end
            PH_TRAIL: begin
                rec.prim_valid = 1'b1;
                if (is_em) begin
                    rec.prim_kind = KIND_GOOD;
                end else begin
                    rec.prim_kind = KIND_TRAIL_ERR;
                    resync        = is_sf;
                end
            end
            default: ;
        endcase
        if (resync) begin
            n_data_count = '0;
            n_crc        = crc_start;
        end
        rec.pass_valid = (n_phase == PH_HUNT) && !is_em;
        rec.rx_byte    = i_rx_byte;
        rec.command    = r_frame_command;
        rec.length     = r_frame_length;
    end

    assign o_rec       = rec;
    assign o_rec_valid = i_accept && (rec.prim_valid || rec.pass_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first    <= SYNC_FIRST_RST;
            r_sync_second   <= SYNC_SECOND_RST;
            r_end_marker    <= END_MARKER_RST;
            r_phase         <= PH_HUNT;
            r_data_count    <= '0;
            r_frame_length  <= '0;
            r_frame_command <= '0;
            r_crc           <= CRC_INIT;
            r_crc_hi        <= '0;
        end else begin
            if (i_cfg.wr_en) begin
                unique case (i_cfg.index)
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg.data;
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg.data;
                    CFG_END_MARKER:  r_end_marker  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_phase         <= n_phase;
                r_data_count    <= n_data_count;
                r_frame_length  <= n_frame_length;
                r_frame_command <= n_frame_command;
                r_crc           <= n_crc;
                r_crc_hi        <= n_crc_hi;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/crcdf_queue.sv =====
// Short record queue between the parser and the result expander.
`default_nettype none

module crcdf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire crcdf_pkg::t_rec i_wr_rec,
    input  wire logic            i_rd,
    output crcdf_pkg::t_rec      o_head,
    output logic                 o_full,
    output logic                 o_empty
);
    import crcdf_pkg::*;

    t_rec                 r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;
    logic                 do_wr, do_rd;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({do_wr, do_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/crcdf_back.sv =====
// Back end: expands each queued record into one or two result transactions.
`default_nettype none

module crcdf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire crcdf_pkg::t_rec i_head,
    input  wire logic            i_q_empty,
    input  wire logic            i_pop,
    output logic                 o_q_rd,
    output logic [2:0]           o_kind,
    output logic [7:0]           o_byte_value,
    output logic [7:0]           o_command,
    output logic [7:0]           o_payload_length,
    output logic                 o_last
);
    import crcdf_pkg::*;

    // set once the frame result of a two-result record has gone out
    logic r_sub;
    logic show_prim, final_sub;

    assign show_prim = i_head.prim_valid && !r_sub;
    assign final_sub = r_sub || !(i_head.prim_valid && i_head.pass_valid);
    assign o_q_rd    = i_pop && !i_q_empty && final_sub;

    always_comb begin
        if (show_prim) begin
            o_kind           = i_head.prim_kind;
            o_byte_value     = (i_head.prim_kind == KIND_PAYLOAD) ? i_head.rx_byte : '0;
            o_command        = i_head.command;
            o_payload_length = i_head.length;
        end else begin
            o_kind           = KIND_PASS;
            o_byte_value     = i_head.rx_byte;
            o_command        = '0;
            o_payload_length = '0;
        end
        o_last = final_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (i_pop && !i_q_empty) begin
            r_sub <= !final_sub;
        end
    end

endmodule

`default_nettype wire
